>>> src/esp_pkg.sv
`timescale 1ns / 1ps

package esp_pkg;

  localparam int DIV_NUM_W = 40;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = 6;

  localparam int SCALE_STEPS = 16;
  localparam int RPM_STEPS   = 33;

  // 60000 * 256
  localparam logic [23:0] RPM_SCALE = 24'd15360000;

  typedef struct packed {
    logic                 start;
    logic [DIV_DEN_W-1:0] rem_init;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_CNT_W-1:0] steps;
  } esp_div_req_t;

endpackage

>>> src/esp_div.sv
`timescale 1ns / 1ps

module esp_div
  import esp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  esp_div_req_t         req_i,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quo_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  // one quotient bit per cycle, numerator bits enter msb first
  assign trial = {rem_q, num_q[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = req_i.rem_init;
      num_d  = req_i.num;
      den_d  = req_i.den;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      num_d = {num_q[DIV_NUM_W-2:0], 1'b0};
      quo_d = {quo_q[DIV_NUM_W-2:0], ge};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_rem_below_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < den_q)
    else $error("partial remainder not below divisor");

  a_done_ends_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("done without a finished division");

endmodule

>>> src/encoder_speed_and_position_top.sv
`timescale 1ns / 1ps
// path: from accept the item passes ST_EVAL, ST_RMUL, ST_RSTART and ST_FIN; the
// rpm division adds ST_RDIV, and rescaling the pulse count adds ST_SMUL and ST_SDIV
// flow: one item at a time, held in ST_FIN by output stalls; the
// bit-serial shared divider (one quotient bit per cycle) sets the pace; the next item
// is taken once the result is registered
// reset: asynchronous, active low; window 10 ms, first poll pending, all totals zero
module encoder_speed_and_position_top
  import esp_pkg::*;
#(
  parameter int COUNTS_PER_REV = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,     // sample_window_ms
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // counter_value[15:0], time_ms[47:16]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o   // pulse_rate[15:0], rpm_q8[48:16],
                                       // total_count[80:49], zero pad
);

  localparam logic [16:0] CprVal = 17'(COUNTS_PER_REV);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_EVAL   = 8'b0000_0010,
    ST_SMUL   = 8'b0000_0100,
    ST_SDIV   = 8'b0000_1000,
    ST_RMUL   = 8'b0001_0000,
    ST_RSTART = 8'b0010_0000,
    ST_RDIV   = 8'b0100_0000,
    ST_FIN    = 8'b1000_0000
  } state_e;

  state_e       state_q, state_d;
  logic         first_q, first_d;
  logic [15:0]  window_q, window_d;
  logic [31:0]  start_time_q, start_time_d;
  logic [15:0]  start_count_q, start_count_d;
  logic [15:0]  held_q, held_d;
  logic [15:0]  last_count_q, last_count_d;
  logic [31:0]  total_q, total_d;
  logic [15:0]  cnt_q, cnt_d;
  logic [31:0]  now_q, now_d;
  logic [31:0]  elapsed_q, elapsed_d;
  logic [30:0]  prod_q, prod_d;
  logic [15:0]  rate_q, rate_d;
  logic [39:0]  rnum_q, rnum_d;
  logic [31:0]  rden_q, rden_d;
  logic [32:0]  rpm_q, rpm_d;
  logic         m_valid_q, m_valid_d;
  logic [87:0]  m_data_q, m_data_d;

  logic         accept;
  logic [15:0]  dpos;
  logic [15:0]  dwin;
  logic [16:0]  pulses;
  logic [32:0]  prod_full;
  logic [32:0]  rden_full;
  logic [17:0]  w3;
  esp_div_req_t div_req;
  logic         div_done;
  logic [DIV_NUM_W-1:0] div_quo;

  esp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign dpos      = s_axis_tdata_i[15:0] - last_count_q;
  assign dwin      = cnt_q - start_count_q;
  assign pulses    = dwin[15] ? (17'd0 - {1'b1, dwin}) : {1'b0, dwin};
  assign prod_full = 33'(pulses) * 33'(window_q);
  assign rden_full = 33'(CprVal) * 33'(window_q);
  assign w3        = {1'b0, window_q, 1'b0} + {2'b00, window_q};

  always_comb begin
    state_d       = state_q;
    first_d       = first_q;
    window_d      = cfg_we_i ? cfg_wdata_i : window_q;
    start_time_d  = start_time_q;
    start_count_d = start_count_q;
    held_d        = held_q;
    last_count_d  = last_count_q;
    total_d       = total_q;
    cnt_d         = cnt_q;
    now_d         = now_q;
    elapsed_d     = elapsed_q;
    prod_d        = prod_q;
    rate_d        = rate_q;
    rnum_d        = rnum_q;
    rden_d        = rden_q;
    rpm_d         = rpm_q;
    m_valid_d     = m_valid_q && !m_axis_tready_i;
    m_data_d      = m_data_q;

    div_req          = '0;
    div_req.den      = rden_q;
    div_req.rem_init = DIV_DEN_W'(rnum_q[39:33]);
    div_req.num      = {rnum_q[32:0], 7'd0};
    div_req.steps    = DIV_CNT_W'(RPM_STEPS);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d        = s_axis_tdata_i[15:0];
          now_d        = s_axis_tdata_i[47:16];
          elapsed_d    = s_axis_tdata_i[47:16] - start_time_q;
          last_count_d = s_axis_tdata_i[15:0];
          total_d      = total_q + {{16{dpos[15]}}, dpos};
          state_d      = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_RMUL;
        if (first_q) begin
          first_d       = 1'b0;
          start_time_d  = now_q;
          start_count_d = cnt_q;
          held_d        = '0;
          rate_d        = '0;
        end else if (elapsed_q < {16'd0, window_q}) begin
          rate_d = held_q;
        end else begin
          start_count_d = cnt_q;
          if (elapsed_q == '0) begin
            rate_d = held_q;
          end else if (elapsed_q > {14'd0, w3}) begin
            start_time_d = now_q;
            held_d       = '0;
            rate_d       = '0;
          end else begin
            start_time_d = now_q;
            prod_d       = prod_full[30:0];
            state_d      = ST_SMUL;
          end
        end
      end
      ST_SMUL: begin
        div_req.start    = 1'b1;
        div_req.den      = elapsed_q;
        div_req.rem_init = DIV_DEN_W'(prod_q[30:16]);
        div_req.num      = {prod_q[15:0], 24'd0};
        div_req.steps    = DIV_CNT_W'(SCALE_STEPS);
        state_d          = ST_SDIV;
      end
      ST_SDIV: begin
        if (div_done) begin
          held_d  = div_quo[15:0];
          rate_d  = div_quo[15:0];
          state_d = ST_RMUL;
        end
      end
      ST_RMUL: begin
        rnum_d  = 40'(rate_q) * 40'(RPM_SCALE);
        rden_d  = rden_full[31:0];
        state_d = ST_RSTART;
      end
      ST_RSTART: begin
        priority if (window_q == '0) begin
          rpm_d   = '0;
          state_d = ST_FIN;
        end else if ({25'd0, rnum_q[39:33]} >= rden_q) begin
          rpm_d   = '1;
          state_d = ST_FIN;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_RDIV;
        end
      end
      ST_RDIV: begin
        if (div_done) begin
          rpm_d   = div_quo[32:0];
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {7'd0, total_q, rpm_q, rate_q};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      first_q       <= 1'b1;
      window_q      <= 16'd10;
      start_time_q  <= '0;
      start_count_q <= '0;
      held_q        <= '0;
      last_count_q  <= '0;
      total_q       <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      first_q       <= first_d;
      window_q      <= window_d;
      start_time_q  <= start_time_d;
      start_count_q <= start_count_d;
      held_q        <= held_d;
      last_count_q  <= last_count_d;
      total_q       <= total_d;
      m_valid_q     <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    now_q     <= now_d;
    elapsed_q <= elapsed_d;
    prod_q    <= prod_d;
    rate_q    <= rate_d;
    rnum_q    <= rnum_d;
    rden_q    <= rden_d;
    rpm_q     <= rpm_d;
    m_data_q  <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  a_accept_eval : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EVAL)
    else $error("accepted item not evaluated");

  a_held_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= 16'd32768)
    else $error("held rate out of range");

  a_first_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(first_q) |-> $past(state_q == ST_EVAL))
    else $error("first poll flag cleared outside evaluation");

  a_valid_from_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result raised outside final state");

endmodule
